// File: src/srtt_pkg.sv
package srtt_pkg;

   localparam int MAX_SERVERS = 32;
   localparam int IDX_W       = $clog2(MAX_SERVERS);
   localparam int CNT_W       = $clog2(MAX_SERVERS + 1);
   localparam int RTT_W       = 16;
   localparam int FAIL_W      = 16;
   localparam int PCT_W       = 7;
   localparam int SEL_W       = 16;
   localparam int BAND_W      = RTT_W + 1;
   localparam int REQ_DATA_W  = 48;
   localparam int RSP_DATA_W  = 40;

   localparam logic [FAIL_W-1:0] FAIL_MAX = {FAIL_W{1'b1}};

   // register indexes on the csr channel
   localparam logic [1:0] CSR_SERVER_COUNT = 2'd0;
   localparam logic [1:0] CSR_UNKNOWN_PCT  = 2'd1;
   localparam logic [1:0] CSR_SLOW_PCT     = 2'd2;

   localparam logic [CNT_W-1:0]  SERVER_COUNT_RST = CNT_W'(26);
   localparam logic [PCT_W-1:0]  UNKNOWN_PCT_RST  = PCT_W'(10);
   localparam logic [PCT_W-1:0]  SLOW_PCT_RST     = PCT_W'(30);

   typedef enum logic [1:0] {
      OP_SELECT  = 2'd0,
      OP_SUCCESS = 2'd1,
      OP_FAILURE = 2'd2
   } op_type;

   typedef enum logic [1:0] {
      STAT_UNKNOWN = 2'd0,
      STAT_SUCCESS = 2'd1,
      STAT_FAIL    = 2'd2
   } status_type;

   typedef enum logic [1:0] {
      CAT_UNKNOWN = 2'd0,
      CAT_FAST    = 2'd1,
      CAT_SLOW    = 2'd2
   } cat_type;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_LEAST,
      ST_CHOOSE,
      ST_COUNT,
      ST_SCALE,
      ST_FIND,
      ST_REPORT,
      ST_DONE
   } state_type;

   typedef struct packed {
      status_type        status;
      logic [RTT_W-1:0]  srtt;
      logic [FAIL_W-1:0] failures;
   } entry_type;

   typedef struct packed {
      logic              en;
      logic [IDX_W-1:0]  addr;
      entry_type         entry;
   } tbl_wr_type;

   // last field in the lowest bits
   typedef struct packed {
      logic [3:0]        pad;
      logic [SEL_W-1:0]  pick;
      logic [PCT_W-1:0]  roll;
      logic [RTT_W-1:0]  rtt_ms;
      logic [4:0]        server_index;
   } req_type;

   typedef struct packed {
      logic [RTT_W-1:0]  smoothed_rtt;
      logic [FAIL_W-1:0] failure_count;
      cat_type           category;
      logic [4:0]        chosen_index;
      logic              found;
   } result_type;

endpackage

// File: src/srtt_table.sv
module srtt_table import srtt_pkg::*; (
   input  logic             clock,
   input  logic             reset,
   input  logic [IDX_W-1:0] rd_addr,
   output entry_type        rd_entry,
   input  tbl_wr_type       wr
);

   entry_type entries_ff [MAX_SERVERS];

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < MAX_SERVERS; i++) begin
            entries_ff[i] <= '{status: STAT_UNKNOWN, srtt: '0, failures: '0};
         end
      end else if (wr.en) begin
         entries_ff[wr.addr] <= wr.entry;
      end
   end

   // single read port, address from the sequencer
   assign rd_entry = entries_ff[rd_addr];

endmodule

// File: src/srtt_server_selector.sv
// channel   dir   handshake              payload
// req       in    req_tvalid/req_tready  tuser: op; tdata: server_index, rtt_ms, roll, pick
// rsp       out   rsp_tvalid/rsp_tready  tdata: found, chosen_index, category,
//                                        failure_count, smoothed_rtt
// csr       in    csr_valid/csr_ready    csr_index, csr_data (always ready)
//
// a select item walks the server table up to three times through one read port:
// least srtt, candidate count, then the chosen candidate; reports skip the scans
// one item at a time: req_tready is high only while the sequencer is idle
// the result sits in an output register; a stalled rsp holds the sequencer in done
// synchronous active-high reset puts every server back to unknown with zero srtt
module srtt_server_selector import srtt_pkg::*; (
   input  logic                  clock,
   input  logic                  reset,
   // request channel
   input  logic                  req_tvalid,
   output logic                  req_tready,
   input  logic [REQ_DATA_W-1:0] req_tdata,  // server_index, rtt_ms, roll, pick, zero pad
   input  logic [1:0]            req_tuser,  // op
   // response channel
   output logic                  rsp_tvalid,
   input  logic                  rsp_tready,
   output logic [RSP_DATA_W-1:0] rsp_tdata,  // found, chosen_index, category,
                                             // failure_count, smoothed_rtt
   // register writes
   input  logic                  csr_valid,
   output logic                  csr_ready,
   input  logic [1:0]            csr_index,
   input  logic [PCT_W-1:0]      csr_data
);

   // configuration registers
   logic [CNT_W-1:0] server_count_ff;
   logic [PCT_W-1:0] unknown_pct_ff;
   logic [PCT_W-1:0] slow_pct_ff;

   // sequencer state
   state_type         state_ff,       state_in;
   logic [CNT_W-1:0]  idx_ff,         idx_in;
   op_type            op_ff,          op_in;
   req_type           req_ff,         req_in;
   logic              any_unknown_ff, any_unknown_in;
   logic              any_success_ff, any_success_in;
   logic [RTT_W-1:0]  least_ff,       least_in;
   cat_type           cat_ff,         cat_in;
   logic [BAND_W-1:0] band_ff,        band_in;
   logic [CNT_W-1:0]  cnt_ff,         cnt_in;
   logic [CNT_W-1:0]  fb_cnt_ff,      fb_cnt_in;
   logic              fallback_ff,    fallback_in;
   logic [CNT_W-1:0]  target_ff,      target_in;
   logic [CNT_W-1:0]  seen_ff,        seen_in;
   result_type        res_ff,         res_in;
   logic              rsp_tvalid_ff,  rsp_tvalid_in;
   result_type        rsp_data_ff,    rsp_data_in;

   logic [CNT_W-1:0]        n_eff;
   logic                    scan_end;
   logic [IDX_W-1:0]        rd_addr;
   entry_type               rd_entry;
   tbl_wr_type              wr;
   logic                    is_cand;
   logic                    not_failed;
   logic                    sel_cand;
   logic [SEL_W+CNT_W-1:0]  scaled;
   logic [RTT_W+3:0]        smooth_sum;
   req_type                 req_view;

   assign req_view = req_type'(req_tdata);

   // a count above the table size is taken as the table size
   assign n_eff = (server_count_ff > CNT_W'(MAX_SERVERS)) ? CNT_W'(MAX_SERVERS)
                                                          : server_count_ff;
   assign scan_end = (idx_ff >= n_eff);

   // report reads the addressed entry, the scans walk the table in order
   assign rd_addr = (state_ff == ST_REPORT) ? req_ff.server_index[IDX_W-1:0]
                                            : idx_ff[IDX_W-1:0];

   srtt_table u_table (
      .clock    (clock),
      .reset    (reset),
      .rd_addr  (rd_addr),
      .rd_entry (rd_entry),
      .wr       (wr)
   );

   // candidate test for the drawn category
   always_comb begin
      case (cat_ff)
         CAT_UNKNOWN: is_cand = (rd_entry.status == STAT_UNKNOWN);
         CAT_FAST:    is_cand = (rd_entry.status == STAT_SUCCESS) &&
                                ({1'b0, rd_entry.srtt} <= band_ff);
         CAT_SLOW:    is_cand = (rd_entry.status == STAT_SUCCESS) &&
                                ({1'b0, rd_entry.srtt} > band_ff);
         default:     is_cand = 1'b0;
      endcase
   end

   assign not_failed = (rd_entry.status != STAT_FAIL);
   assign sel_cand   = fallback_ff ? not_failed : is_cand;

   // pick scaled by the candidate count, top bits give the target position
   assign scaled = {{CNT_W{1'b0}}, req_ff.pick} * {{SEL_W{1'b0}}, cnt_ff};

   // 7*srtt + rtt written as 8*srtt - srtt + rtt
   assign smooth_sum = ({4'b0, rd_entry.srtt} << 3) - {4'b0, rd_entry.srtt}
                       + {4'b0, req_ff.rtt_ms};

   // configuration, always accepted
   assign csr_ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         server_count_ff <= SERVER_COUNT_RST;
         unknown_pct_ff  <= UNKNOWN_PCT_RST;
         slow_pct_ff     <= SLOW_PCT_RST;
      end else if (csr_valid) begin
         case (csr_index)
            CSR_SERVER_COUNT: server_count_ff <= csr_data[CNT_W-1:0];
            CSR_UNKNOWN_PCT:  unknown_pct_ff  <= csr_data;
            CSR_SLOW_PCT:     slow_pct_ff     <= csr_data;
            default:          ;
         endcase
      end
   end

   // sequencer
   always_comb begin
      state_in       = state_ff;
      idx_in         = idx_ff;
      op_in          = op_ff;
      req_in         = req_ff;
      any_unknown_in = any_unknown_ff;
      any_success_in = any_success_ff;
      least_in       = least_ff;
      cat_in         = cat_ff;
      band_in        = band_ff;
      cnt_in         = cnt_ff;
      fb_cnt_in      = fb_cnt_ff;
      fallback_in    = fallback_ff;
      target_in      = target_ff;
      seen_in        = seen_ff;
      res_in         = res_ff;
      rsp_tvalid_in  = rsp_tvalid_ff;
      rsp_data_in    = rsp_data_ff;
      wr             = '0;
      req_tready     = 1'b0;

      if (rsp_tvalid_ff && rsp_tready) begin
         rsp_tvalid_in = 1'b0;
      end

      case (state_ff)
         ST_IDLE: begin
            req_tready = 1'b1;
            if (req_tvalid) begin
               op_in          = op_type'(req_tuser);
               req_in         = req_view;
               res_in         = '0;
               idx_in         = '0;
               any_unknown_in = 1'b0;
               any_success_in = 1'b0;
               least_in       = '0;
               fallback_in    = 1'b0;
               case (op_type'(req_tuser))
                  OP_SELECT:  state_in = ST_LEAST;
                  OP_SUCCESS: state_in = ST_REPORT;
                  OP_FAILURE: state_in = ST_REPORT;
                  default:    state_in = ST_DONE;
               endcase
            end
         end

         // first pass: whether unknown or successful servers exist and the least srtt among successes
         ST_LEAST: begin
            if (scan_end) begin
               state_in = ST_CHOOSE;
            end else begin
               if (rd_entry.status == STAT_UNKNOWN) begin
                  any_unknown_in = 1'b1;
               end
               if (rd_entry.status == STAT_SUCCESS) begin
                  any_success_in = 1'b1;
                  if (!any_success_ff || (rd_entry.srtt < least_ff)) begin
                     least_in = rd_entry.srtt;
                  end
               end
               idx_in = idx_ff + 1'b1;
            end
         end

         ST_CHOOSE: begin
            if (any_unknown_ff && (!any_success_ff || (req_ff.roll <= unknown_pct_ff))) begin
               cat_in = CAT_UNKNOWN;
            end else if (req_ff.roll <= slow_pct_ff) begin
               cat_in = CAT_SLOW;
            end else begin
               cat_in = CAT_FAST;
            end
            // fast band edge: least + least/4
            band_in   = {1'b0, least_ff} + {3'b0, least_ff[RTT_W-1:2]};
            idx_in    = '0;
            cnt_in    = '0;
            fb_cnt_in = '0;
            state_in  = ST_COUNT;
         end

         // second pass: candidates of the category and non-failed servers
         ST_COUNT: begin
            if (scan_end) begin
               if (cnt_ff == '0) begin
                  fallback_in = 1'b1;
                  cnt_in      = fb_cnt_ff;
               end
               state_in = ST_SCALE;
            end else begin
               if (is_cand) begin
                  cnt_in = cnt_ff + 1'b1;
               end
               if (not_failed) begin
                  fb_cnt_in = fb_cnt_ff + 1'b1;
               end
               idx_in = idx_ff + 1'b1;
            end
         end

         ST_SCALE: begin
            if (cnt_ff == '0) begin
               state_in = ST_DONE;
            end else begin
               target_in = scaled[SEL_W+CNT_W-1:SEL_W];
               idx_in    = '0;
               seen_in   = '0;
               state_in  = ST_FIND;
            end
         end

         // third pass: stop at the target-th candidate
         ST_FIND: begin
            if (scan_end) begin
               state_in = ST_DONE;
            end else begin
               if (sel_cand) begin
                  if (seen_ff == target_ff) begin
                     res_in.found        = 1'b1;
                     res_in.chosen_index = 5'(idx_ff);
                     res_in.category     = cat_ff;
                     state_in            = ST_DONE;
                  end else begin
                     seen_in = seen_ff + 1'b1;
                  end
               end
               idx_in = idx_ff + 1'b1;
            end
         end

         // read-modify-write of the reported entry
         ST_REPORT: begin
            state_in = ST_DONE;
            if ({1'b0, req_ff.server_index} < n_eff) begin
               wr.en    = 1'b1;
               wr.addr  = req_ff.server_index[IDX_W-1:0];
               wr.entry = rd_entry;
               if (op_ff == OP_SUCCESS) begin
                  wr.entry.status   = STAT_SUCCESS;
                  wr.entry.failures = '0;
                  if (rd_entry.srtt == '0) begin
                     wr.entry.srtt = req_ff.rtt_ms;
                  end else begin
                     wr.entry.srtt = smooth_sum[RTT_W+2:3];
                  end
               end else begin
                  wr.entry.status = STAT_FAIL;
                  if (rd_entry.failures != FAIL_MAX) begin
                     wr.entry.failures = rd_entry.failures + 1'b1;
                  end
               end
               res_in.failure_count = wr.entry.failures;
               res_in.smoothed_rtt  = wr.entry.srtt;
            end
         end

         ST_DONE: begin
            if (!rsp_tvalid_ff || rsp_tready) begin
               rsp_tvalid_in = 1'b1;
               rsp_data_in   = res_ff;
               state_in      = ST_IDLE;
            end
         end

         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= ST_IDLE;
         rsp_tvalid_ff <= 1'b0;
      end else begin
         state_ff      <= state_in;
         rsp_tvalid_ff <= rsp_tvalid_in;
      end
   end

   // payload and scan registers
   always_ff @(posedge clock) begin
      idx_ff         <= idx_in;
      op_ff          <= op_in;
      req_ff         <= req_in;
      any_unknown_ff <= any_unknown_in;
      any_success_ff <= any_success_in;
      least_ff       <= least_in;
      cat_ff         <= cat_in;
      band_ff        <= band_in;
      cnt_ff         <= cnt_in;
      fb_cnt_ff      <= fb_cnt_in;
      fallback_ff    <= fallback_in;
      target_ff      <= target_in;
      seen_ff        <= seen_in;
      res_ff         <= res_in;
      rsp_data_ff    <= rsp_data_in;
   end

   assign rsp_tvalid = rsp_tvalid_ff;
   assign rsp_tdata  = rsp_data_ff;

endmodule
